// ===== hdl/x11srp_pkg.sv =====
// Shared types, codes and helpers for the X11 setup request parser.
// No dependencies; every other file of the block uses this package.
package x11srp_pkg;

	localparam int COUNT_BITS_DEF = 18;
	localparam int HDR_SIZE       = 12;
	localparam int CFG_IDX_BITS   = 2;
	localparam int CFG_DATA_BITS  = 18;
	localparam int MAX_SIZE_BITS  = 18;

	// parse status codes
	localparam logic [2:0] ST_NEED  = 3'd0;
	localparam logic [2:0] ST_DONE  = 3'd1;
	localparam logic [2:0] ST_ORDER = 3'd2;
	localparam logic [2:0] ST_LARGE = 3'd3;
	localparam logic [2:0] ST_TRUNC = 3'd4;

	// byte roles
	localparam logic [2:0] ROLE_HDR      = 3'd0;
	localparam logic [2:0] ROLE_NAME     = 3'd1;
	localparam logic [2:0] ROLE_NAME_PAD = 3'd2;
	localparam logic [2:0] ROLE_DATA     = 3'd3;
	localparam logic [2:0] ROLE_DATA_PAD = 3'd4;

	// decision codes
	localparam logic [1:0] DEC_ACCEPT   = 2'd0;
	localparam logic [1:0] DEC_BAD_VER  = 2'd1;
	localparam logic [1:0] DEC_BAD_AUTH = 2'd2;

	// operations
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_END  = 1'b1;

	// byte order markers
	localparam logic [7:0] MARK_MSB = 8'h42;
	localparam logic [7:0] MARK_LSB = 8'h6C;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_SIZE = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_EXP_MAJ  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_EXP_MIN  = 2'd2;

	// configuration reset values
	localparam logic [MAX_SIZE_BITS-1:0] MAX_SIZE_RST = 18'd131084;
	localparam logic [15:0]              EXP_MAJ_RST  = 16'd11;
	localparam logic [15:0]              EXP_MIN_RST  = 16'd0;

	typedef struct packed {
		logic       operation;
		logic [7:0] data_byte;
	} req_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        consumed;
		logic [2:0]  byte_role;
		logic [7:0]  payload_byte;
		logic        msb_first;
		logic [15:0] client_major;
		logic [15:0] client_minor;
		logic [15:0] name_length;
		logic [15:0] data_length;
		logic [1:0]  decision;
	} rsp_item_t;

	typedef struct packed {
		logic [CFG_IDX_BITS-1:0]  reg_index;
		logic [CFG_DATA_BITS-1:0] wr_data;
	} cfg_word_t;

	typedef struct packed {
		logic [MAX_SIZE_BITS-1:0] max_size;
		logic [15:0]              exp_major;
		logic [15:0]              exp_minor;
	} cfg_regs_t;

	// round a 16-bit length up to a multiple of 4
	function automatic logic [16:0] pad4(input logic [15:0] v);
		logic [16:0] s;
		s = {1'b0, v} + 17'd3;
		return {s[16:2], 2'b00};
	endfunction

endpackage

// ===== hdl/x11srp_if.sv =====
// Valid/ready channel interfaces: request words, result words, config writes.
// Depends on x11srp_pkg for the payload types.
interface x11srp_req_if;
	logic                 valid;
	logic                 ready;
	x11srp_pkg::req_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface x11srp_rsp_if;
	logic                 valid;
	logic                 ready;
	x11srp_pkg::rsp_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface x11srp_cfg_if;
	logic                 valid;
	logic                 ready;
	x11srp_pkg::cfg_word_t payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/x11srp_cfg.sv =====
// Configuration register file: max size and expected protocol version.
// Depends on x11srp_pkg and x11srp_if.
module x11srp_cfg (
	input  logic                  clk,
	input  logic                  arst_n,
	x11srp_cfg_if.sink            cfg,
	output x11srp_pkg::cfg_regs_t regs
);

	x11srp_pkg::cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.max_size  <= x11srp_pkg::MAX_SIZE_RST;
			regs_q.exp_major <= x11srp_pkg::EXP_MAJ_RST;
			regs_q.exp_minor <= x11srp_pkg::EXP_MIN_RST;
		end else if (cfg.valid) begin
			case (cfg.payload.reg_index)
				x11srp_pkg::REG_MAX_SIZE: begin
					regs_q.max_size <= cfg.payload.wr_data[x11srp_pkg::MAX_SIZE_BITS-1:0];
				end
				x11srp_pkg::REG_EXP_MAJ: begin
					regs_q.exp_major <= cfg.payload.wr_data[15:0];
				end
				x11srp_pkg::REG_EXP_MIN: begin
					regs_q.exp_minor <= cfg.payload.wr_data[15:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== hdl/x11srp_core.sv =====
// Parse state registers and the one-word step logic.
// Depends on x11srp_pkg.
module x11srp_core #(
	parameter int COUNT_BITS = x11srp_pkg::COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  x11srp_pkg::req_item_t item,
	input  x11srp_pkg::cfg_regs_t regs,
	output x11srp_pkg::rsp_item_t result
);

	localparam logic [COUNT_BITS-1:0] HDR_C = COUNT_BITS'(x11srp_pkg::HDR_SIZE);
	localparam logic [COUNT_BITS-1:0] ONE_C = COUNT_BITS'(1);

	logic [COUNT_BITS-1:0] count_q, count_n;
	logic [COUNT_BITS-1:0] total_q, total_n;
	logic [2:0]            status_q, status_n;
	logic                  msb_q, msb_n;
	logic [15:0]           major_q, major_n;
	logic [15:0]           minor_q, minor_n;
	logic [15:0]           nlen_q, nlen_n;
	logic [15:0]           dlen_q, dlen_n;

	logic [COUNT_BITS-1:0] off;
	logic [COUNT_BITS-1:0] name_end, name_pad_end, data_end;
	logic [17:0]           total;
	logic [2:0]            which_w;
	logic                  high;
	logic                  taken;
	logic [2:0]            role;

	assign off          = count_q;
	assign name_end     = HDR_C + COUNT_BITS'(nlen_q);
	assign name_pad_end = HDR_C + COUNT_BITS'(x11srp_pkg::pad4(nlen_q));
	assign data_end     = name_pad_end + COUNT_BITS'(dlen_q);
	assign total        = 18'(x11srp_pkg::HDR_SIZE) + 18'(x11srp_pkg::pad4(nlen_q))
	                    + 18'(x11srp_pkg::pad4(dlen_q));
	assign which_w      = off[3:1] - 3'd1;
	assign high         = msb_q ? ~off[0] : off[0];

	always_comb begin
		count_n  = count_q;
		total_n  = total_q;
		status_n = status_q;
		msb_n    = msb_q;
		major_n  = major_q;
		minor_n  = minor_q;
		nlen_n   = nlen_q;
		dlen_n   = dlen_q;
		taken    = 1'b0;
		role     = x11srp_pkg::ROLE_HDR;

		// limit below header size rejects before the first byte
		if (status_n == x11srp_pkg::ST_NEED && count_q == '0 &&
		    regs.max_size < x11srp_pkg::MAX_SIZE_BITS'(x11srp_pkg::HDR_SIZE))
			status_n = x11srp_pkg::ST_LARGE;

		if (item.operation == x11srp_pkg::OP_END) begin
			if (status_n == x11srp_pkg::ST_NEED)
				status_n = x11srp_pkg::ST_TRUNC;
		end else if (status_n == x11srp_pkg::ST_NEED) begin
			taken = 1'b1;
			if (off == '0) begin
				if (item.data_byte == x11srp_pkg::MARK_MSB)
					msb_n = 1'b1;
				else if (item.data_byte == x11srp_pkg::MARK_LSB)
					msb_n = 1'b0;
				else
					status_n = x11srp_pkg::ST_ORDER;
			end else if (off < HDR_C) begin
				if (off[3:0] >= 4'd2 && off[3:0] <= 4'd9) begin
					case (which_w[1:0])
						2'd0: begin
							if (high) major_n[15:8] = item.data_byte;
							else      major_n[7:0]  = item.data_byte;
						end
						2'd1: begin
							if (high) minor_n[15:8] = item.data_byte;
							else      minor_n[7:0]  = item.data_byte;
						end
						2'd2: begin
							if (high) nlen_n[15:8] = item.data_byte;
							else      nlen_n[7:0]  = item.data_byte;
						end
						default: begin
							if (high) dlen_n[15:8] = item.data_byte;
							else      dlen_n[7:0]  = item.data_byte;
						end
					endcase
				end
			end else begin
				if (off < name_end)          role = x11srp_pkg::ROLE_NAME;
				else if (off < name_pad_end) role = x11srp_pkg::ROLE_NAME_PAD;
				else if (off < data_end)     role = x11srp_pkg::ROLE_DATA;
				else                         role = x11srp_pkg::ROLE_DATA_PAD;
			end

			if (status_n == x11srp_pkg::ST_NEED) begin
				count_n = count_q + ONE_C;
				// last header byte: lengths are final, fix the total
				if (off == HDR_C - ONE_C) begin
					if (total > regs.max_size)
						status_n = x11srp_pkg::ST_LARGE;
					else
						total_n = COUNT_BITS'(total);
				end
				if (status_n == x11srp_pkg::ST_NEED && count_n >= HDR_C &&
				    count_n == total_n)
					status_n = x11srp_pkg::ST_DONE;
			end
		end
	end

	always_comb begin
		result.status       = status_n;
		result.consumed     = taken;
		result.byte_role    = role;
		result.payload_byte = taken ? item.data_byte : 8'd0;
		result.msb_first    = msb_n;
		result.client_major = major_n;
		result.client_minor = minor_n;
		result.name_length  = nlen_n;
		result.data_length  = dlen_n;
		result.decision     = x11srp_pkg::DEC_ACCEPT;
		if (status_n == x11srp_pkg::ST_DONE) begin
			if (major_n != regs.exp_major || minor_n != regs.exp_minor)
				result.decision = x11srp_pkg::DEC_BAD_VER;
			else if (nlen_n != 16'd0 || dlen_n != 16'd0)
				result.decision = x11srp_pkg::DEC_BAD_AUTH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			total_q  <= HDR_C;
			status_q <= x11srp_pkg::ST_NEED;
			msb_q    <= 1'b0;
			major_q  <= '0;
			minor_q  <= '0;
			nlen_q   <= '0;
			dlen_q   <= '0;
		end else if (step) begin
			count_q  <= count_n;
			total_q  <= total_n;
			status_q <= status_n;
			msb_q    <= msb_n;
			major_q  <= major_n;
			minor_q  <= minor_n;
			nlen_q   <= nlen_n;
			dlen_q   <= dlen_n;
		end
	end

endmodule

// ===== hdl/x11_setup_request_parser.sv =====
// Top level of the X11 connection setup request parser.
// Depends on x11srp_pkg, x11srp_if, x11srp_cfg and x11srp_core.
//
// Parses an X11 connection setup request one word (one byte or an end
// marker) per request. Each accepted word yields exactly one result word
// carrying the parse status, whether the byte was consumed, its role
// (header, name, name pad, data, data pad), the echoed byte, the header
// fields captured so far and, once complete, the accept decision. The block
// takes one word per clock while results are taken; a word passes the input
// register, then the step logic into the result register. The rate is set
// by the parse state update, which happens once per word. A result left
// waiting stalls the input register, which once full holds off the next
// request. Configuration writes take effect at once and are meant to be
// issued while no result is pending; writes to unknown indexes are ignored.
// Once the status leaves need-more the parser holds it until reset.
module x11_setup_request_parser #(
	parameter int COUNT_BITS = x11srp_pkg::COUNT_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	x11srp_req_if.sink   req,
	x11srp_rsp_if.source rsp,
	x11srp_cfg_if.sink   cfg
);

	x11srp_pkg::cfg_regs_t regs;
	x11srp_pkg::req_item_t item_s1;
	x11srp_pkg::rsp_item_t result;
	x11srp_pkg::rsp_item_t rsp_q;
	logic                  valid_s1;
	logic                  rsp_valid_q;
	logic                  advance;
	logic                  step;

	// s1 moves on when the result register is empty or being drained
	assign advance   = !rsp_valid_q || rsp.ready;
	assign step      = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	x11srp_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	x11srp_core #(
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.regs   (regs),
		.result (result)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.payload;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (step) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rsp_q <= result;
		end
	end

endmodule

// ===== hdl/x11srp_checker.sv =====
// Port-level checks for the X11 setup request parser, bound to the top level.
// Depends on x11srp_pkg and x11_setup_request_parser.
module x11srp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [2:0] status,
	input logic       consumed,
	input logic [2:0] byte_role,
	input logic [7:0] payload_byte,
	input logic [1:0] decision
);

	// a result stays offered until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	// an end marker never consumes a byte
	a_trunc_not_taken: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && consumed |-> status != x11srp_pkg::ST_TRUNC)
		else $error("byte consumed with truncated status");

	// decision only meaningful when complete
	a_decision_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && decision != x11srp_pkg::DEC_ACCEPT |-> status == x11srp_pkg::ST_DONE)
		else $error("decision set without completion");

	// untaken byte leaves role and echo clear
	a_untaken_clear: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !consumed |-> byte_role == x11srp_pkg::ROLE_HDR && payload_byte == 8'd0)
		else $error("role or echo set on untaken byte");

endmodule

bind x11_setup_request_parser x11srp_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.status       (rsp.payload.status),
	.consumed     (rsp.payload.consumed),
	.byte_role    (rsp.payload.byte_role),
	.payload_byte (rsp.payload.payload_byte),
	.decision     (rsp.payload.decision)
);
